// ----- rtl/dlps_pkg.sv -----
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types, codes and helpers for the delta-list processor scheduler.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int MAX_PROCS_DEF = 4;
    localparam int NUM_SPEEDS    = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int ACTIVE_W      = 3;
    localparam int SPEED_W       = 32;
    localparam int FUNC_W        = 2;
    localparam int ID_W          = 2;
    localparam int TICK_W        = 20;
    localparam int BUDGET_W      = 31;
    localparam int STATUS_W      = 2;
    localparam int TIME_W        = 64;
    localparam int HALF_W        = 32;

    localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
    localparam logic [TIME_W-1:0]   BUDGET_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [BUDGET_W-1:0] BUDGET_SAT = '1;

    // item functions
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RAN     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LCM_OVF = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED0 = 3'd1;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_RS_INIT,
        CMD_GCD_LOAD,
        CMD_DIV_GCD,
        CMD_GCD_SHIFT,
        CMD_DIV_LQ,
        CMD_MUL_LCM,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_LCM_UPD,
        CMD_FAC_START,
        CMD_DIV_FAC,
        CMD_FAC_WRITE,
        CMD_FAC_ZERO,
        CMD_RAN_PREP,
        CMD_RAN_T,
        CMD_REMOVE,
        CMD_PLACE_STEP,
        CMD_PLACE_INS,
        CMD_SEARCH_INIT,
        CMD_SEARCH_STEP,
        CMD_BAD_ID,
        CMD_PAUSE_MUL,
        CMD_PAUSE_APPLY,
        CMD_DIV_BUD,
        CMD_BUD_SAVE,
        CMD_OUT_LOAD
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              div_done;
        logic              rem_zero;
        logic              rs_more;
        logic              i_lt_max;
        logic              i_lt_n;
        logic              multi;
        logic              p_lt_n;
        logic              p_hit;
        logic              pause_moves;
        logic              place_more;
    } dp_stat_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// ----- rtl/dlps_div.sv -----
// ----------------------------------------------------------------------------
// dlps_div
// Iterative 64/64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlps_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dlps_pkg::TIME_W-1:0] dividend,
    input  logic [dlps_pkg::TIME_W-1:0] divisor,
    output logic [dlps_pkg::TIME_W-1:0] quot,
    output logic [dlps_pkg::TIME_W-1:0] rem,
    output logic                       done
);
    import dlps_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    logic [TIME_W-1:0] quot_reg, quot_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[TIME_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[TIME_W])
            begin
                rem_next  = trial[TIME_W-1:0];
                quot_next = {quot_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[TIME_W-1:0];
                quot_next = {quot_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ----- rtl/dlps_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlps_ctrl
// Sequencer: steps the datapath through restart, ran and pause items.
// ----------------------------------------------------------------------------
module dlps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dlps_pkg::dp_stat_t stat,
    output dlps_pkg::dp_cmd_t  cmd
);
    import dlps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RS_LOOP,
        S_GCD_DIV,
        S_GCD_WAIT,
        S_LQ_WAIT,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_DONE,
        S_FAC,
        S_FAC_WAIT,
        S_REMOVE,
        S_PLACE,
        S_SEARCH,
        S_BUDGET,
        S_BUD_WAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_NOP;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.func)
                    FUNC_RESTART:
                    begin
                        cmd        = CMD_RS_INIT;
                        state_next = S_RS_LOOP;
                    end
                    FUNC_RAN:
                    begin
                        if (stat.multi)
                        begin
                            cmd        = CMD_RAN_PREP;
                            state_next = S_MUL_LO;
                        end
                        else
                            state_next = S_BUDGET;
                    end
                    FUNC_PAUSE:
                    begin
                        cmd        = CMD_SEARCH_INIT;
                        state_next = S_SEARCH;
                    end
                    default: state_next = S_BUDGET;
                endcase
            end
            S_RS_LOOP:
            begin
                if (stat.rs_more)
                begin
                    cmd        = CMD_GCD_LOAD;
                    state_next = S_GCD_DIV;
                end
                else
                begin
                    cmd        = CMD_FAC_START;
                    state_next = S_FAC;
                end
            end
            S_GCD_DIV:
            begin
                cmd        = CMD_DIV_GCD;
                state_next = S_GCD_WAIT;
            end
            S_GCD_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd        = CMD_DIV_LQ;
                        state_next = S_LQ_WAIT;
                    end
                    else
                    begin
                        cmd        = CMD_GCD_SHIFT;
                        state_next = S_GCD_DIV;
                    end
                end
            end
            S_LQ_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd        = CMD_MUL_LCM;
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd        = CMD_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd        = CMD_MUL_HI;
                state_next = S_MUL_DONE;
            end
            S_MUL_DONE:
            begin
                case (stat.func)
                    FUNC_RESTART:
                    begin
                        cmd        = CMD_LCM_UPD;
                        state_next = S_RS_LOOP;
                    end
                    FUNC_RAN:
                    begin
                        cmd        = CMD_RAN_T;
                        state_next = S_REMOVE;
                    end
                    FUNC_PAUSE:
                    begin
                        cmd        = CMD_PAUSE_APPLY;
                        state_next = stat.pause_moves ? S_REMOVE : S_BUDGET;
                    end
                    default: state_next = S_BUDGET;
                endcase
            end
            S_FAC:
            begin
                if (!stat.i_lt_max)
                    state_next = S_BUDGET;
                else if (stat.i_lt_n)
                begin
                    cmd        = CMD_DIV_FAC;
                    state_next = S_FAC_WAIT;
                end
                else
                    cmd = CMD_FAC_ZERO;
            end
            S_FAC_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd        = CMD_FAC_WRITE;
                    state_next = S_FAC;
                end
            end
            S_REMOVE:
            begin
                cmd        = CMD_REMOVE;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (stat.place_more)
                    cmd = CMD_PLACE_STEP;
                else
                begin
                    cmd        = CMD_PLACE_INS;
                    state_next = S_BUDGET;
                end
            end
            S_SEARCH:
            begin
                if (!stat.p_lt_n)
                begin
                    cmd        = CMD_BAD_ID;
                    state_next = S_BUDGET;
                end
                else if (stat.p_hit)
                begin
                    cmd        = CMD_PAUSE_MUL;
                    state_next = S_MUL_LO;
                end
                else
                    cmd = CMD_SEARCH_STEP;
            end
            S_BUDGET:
            begin
                if (stat.multi)
                begin
                    cmd        = CMD_DIV_BUD;
                    state_next = S_BUD_WAIT;
                end
                else
                    state_next = S_DONE;
            end
            S_BUD_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd        = CMD_BUD_SAVE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = CMD_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while another is in work");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_OUT_LOAD) |-> (!out_valid_reg || out_ready))
        else $error("result overwrites one not yet taken");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_OUT_LOAD) |=> out_valid)
        else $error("loaded result not presented");

endmodule

// ----- rtl/dlps_dp.sv -----
// ----------------------------------------------------------------------------
// dlps_dp
// Datapath: config registers, delta list, factors, multiplier and divider.
// ----------------------------------------------------------------------------
module dlps_dp #(
    parameter int MAX_PROCS = dlps_pkg::MAX_PROCS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dlps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [dlps_pkg::FUNC_W-1:0]     func,
    input  logic [dlps_pkg::ID_W-1:0]       proc_id,
    input  logic [dlps_pkg::TICK_W-1:0]     tick_count,
    input  dlps_pkg::dp_cmd_t               cmd,
    output dlps_pkg::dp_stat_t              stat,
    output logic [dlps_pkg::ID_W-1:0]       head_id,
    output logic [dlps_pkg::BUDGET_W-1:0]   budget,
    output logic                           alone,
    output logic [dlps_pkg::STATUS_W-1:0]   status
);
    import dlps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // configuration
    logic [ACTIVE_W-1:0] active_reg, active_next;
    logic [SPEED_W-1:0]  speed_reg [NUM_SPEEDS];
    logic [SPEED_W-1:0]  speed_next [NUM_SPEEDS];

    // item
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;

    // schedule
    logic [CNT_W-1:0]    nsched_reg, nsched_next;
    logic [IDX_W-1:0]    order_reg [MAX_PROCS];
    logic [IDX_W-1:0]    order_next [MAX_PROCS];
    logic [TIME_W-1:0]   delta_reg [MAX_PROCS];
    logic [TIME_W-1:0]   delta_next [MAX_PROCS];
    logic [TIME_W-1:0]   factor_reg [MAX_PROCS];
    logic [TIME_W-1:0]   factor_next [MAX_PROCS];

    // working registers
    logic [TIME_W-1:0]   l_reg, l_next, ga_reg, ga_next, gb_reg, gb_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [IDX_W-1:0]    pos_reg, pos_next, pid_reg, pid_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [TIME_W-1:0]   mul_a_reg, mul_a_next;
    logic [HALF_W-1:0]   mul_b_reg, mul_b_next;
    logic [TIME_W-1:0]   p_lo_reg, p_lo_next, p_hi_reg, p_hi_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic [BUDGET_W-1:0] bud_reg, bud_next;

    // result
    logic [ID_W-1:0]     head_reg, head_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic                alone_reg, alone_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // combinational helpers
    logic [SPEED_W-1:0]  speed_i;
    logic [CNT_W-1:0]    n_clamp;
    logic [IDX_W-1:0]    i_idx, j_idx, p1_idx;
    logic [HALF_W-1:0]   mul_src;
    logic [TIME_W-1:0]   mul_out;
    logic [HALF_W:0]     mid_sum;
    logic                prod_ovf;
    logic [TIME_W-1:0]   prod_sat;
    logic [TIME_W-1:0]   fac_head;
    logic                p1_in;
    logic                div_start;
    logic [TIME_W-1:0]   div_a, div_b, div_quot, div_rem;
    logic                div_done;

    assign i_idx  = i_reg[IDX_W-1:0];
    assign j_idx  = j_reg[IDX_W-1:0];
    assign p1_idx = IDX_W'(int'(pos_reg) + 1);
    assign p1_in  = (int'(pos_reg) + 1) < int'(nsched_reg);

    always_comb
    begin
        speed_i = SPEED_W'(1);
        if (int'(i_reg) < NUM_SPEEDS && speed_reg[i_reg[1:0]] != '0)
            speed_i = speed_reg[i_reg[1:0]];
    end

    always_comb
    begin
        if (active_reg == '0)
            n_clamp = CNT_W'(1);
        else if (int'(active_reg) > MAX_PROCS)
            n_clamp = CNT_W'(MAX_PROCS);
        else
            n_clamp = CNT_W'(active_reg);
    end

    // one 32x32 multiplier, low then high half of the 64-bit operand
    assign mul_src  = (cmd == CMD_MUL_HI) ? mul_a_reg[TIME_W-1:HALF_W] : mul_a_reg[HALF_W-1:0];
    assign mul_out  = mul_src * mul_b_reg;
    assign mid_sum  = {1'b0, p_hi_reg[HALF_W-1:0]} + {1'b0, p_lo_reg[TIME_W-1:HALF_W]};
    assign prod_ovf = (p_hi_reg[TIME_W-1:HALF_W] != '0) || mid_sum[HALF_W];
    assign prod_sat = prod_ovf ? TIME_MAX : {mid_sum[HALF_W-1:0], p_lo_reg[HALF_W-1:0]};

    assign fac_head = factor_reg[order_reg[0]];

    always_comb
    begin
        div_start = 1'b1;
        div_a     = ga_reg;
        div_b     = gb_reg;
        case (cmd)
            CMD_DIV_GCD: ;
            CMD_DIV_LQ:  div_a = l_reg;
            CMD_DIV_FAC:
            begin
                div_a = l_reg;
                div_b = TIME_W'(speed_i);
            end
            CMD_DIV_BUD:
            begin
                div_a = delta_reg[1];
                div_b = (fac_head == '0) ? TIME_W'(1) : fac_head;
            end
            default: div_start = 1'b0;
        endcase
    end

    dlps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_comb
    begin
        stat.func        = func_reg;
        stat.div_done    = div_done;
        stat.rem_zero    = (div_rem == '0);
        stat.rs_more     = (i_reg < nsched_reg) && !ovf_reg;
        stat.i_lt_max    = int'(i_reg) < MAX_PROCS;
        stat.i_lt_n      = i_reg < nsched_reg;
        stat.multi       = int'(nsched_reg) >= 2;
        stat.p_lt_n      = j_reg < nsched_reg;
        stat.p_hit       = int'(order_reg[j_idx]) == int'(id_reg);
        stat.pause_moves = p1_in && (prod_sat > delta_reg[p1_idx]);
        stat.place_more  = (j_reg < m_reg) && (t_reg > delta_reg[j_idx]);
    end

    always_comb
    begin
        active_next = active_reg;
        speed_next  = speed_reg;
        func_next   = func_reg;
        id_next     = id_reg;
        ticks_next  = ticks_reg;
        nsched_next = nsched_reg;
        order_next  = order_reg;
        delta_next  = delta_reg;
        factor_next = factor_reg;
        l_next      = l_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        pos_next    = pos_reg;
        pid_next    = pid_reg;
        t_next      = t_reg;
        mul_a_next  = mul_a_reg;
        mul_b_next  = mul_b_reg;
        p_lo_next   = p_lo_reg;
        p_hi_next   = p_hi_reg;
        code_next   = code_reg;
        bud_next    = bud_reg;
        head_next   = head_reg;
        budget_next = budget_reg;
        alone_next  = alone_reg;
        status_next = status_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_ACTIVE)
                active_next = cfg_data[ACTIVE_W-1:0];
            else if (int'(cfg_index) <= NUM_SPEEDS)
                speed_next[2'(cfg_index - CFG_SPEED0)] = cfg_data[SPEED_W-1:0];
        end

        case (cmd)
            CMD_LATCH:
            begin
                func_next  = func;
                id_next    = proc_id;
                ticks_next = tick_count;
                code_next  = ST_OK;
            end
            CMD_RS_INIT:
            begin
                nsched_next = n_clamp;
                l_next      = TIME_W'(1);
                ovf_next    = 1'b0;
                i_next      = '0;
                for (int k = 0; k < MAX_PROCS; k++)
                begin
                    order_next[k] = IDX_W'(k);
                    delta_next[k] = '0;
                end
            end
            CMD_GCD_LOAD:
            begin
                ga_next = l_reg;
                gb_next = TIME_W'(speed_i);
            end
            CMD_GCD_SHIFT:
            begin
                ga_next = gb_reg;
                gb_next = div_rem;
            end
            CMD_MUL_LCM:
            begin
                mul_a_next = div_quot;
                mul_b_next = speed_i;
            end
            CMD_MUL_LO: p_lo_next = mul_out;
            CMD_MUL_HI: p_hi_next = mul_out;
            CMD_LCM_UPD:
            begin
                if (prod_ovf)
                begin
                    l_next   = TIME_MAX;
                    ovf_next = 1'b1;
                end
                else
                    l_next = prod_sat;
                i_next = i_reg + 1'b1;
            end
            CMD_FAC_START:
            begin
                i_next    = '0;
                code_next = ovf_reg ? ST_LCM_OVF : ST_OK;
            end
            CMD_FAC_WRITE:
            begin
                factor_next[i_idx] = div_quot;
                i_next             = i_reg + 1'b1;
            end
            CMD_FAC_ZERO:
            begin
                factor_next[i_idx] = '0;
                i_next             = i_reg + 1'b1;
            end
            CMD_RAN_PREP:
            begin
                pid_next   = order_reg[0];
                mul_a_next = fac_head;
                mul_b_next = HALF_W'(ticks_reg);
            end
            CMD_RAN_T:
            begin
                t_next   = prod_sat;
                pos_next = '0;
            end
            CMD_REMOVE:
            begin
                for (int k = 0; k < MAX_PROCS - 1; k++)
                begin
                    if (k >= int'(pos_reg) && (k + 1) < int'(nsched_reg))
                    begin
                        order_next[k] = order_reg[k + 1];
                        delta_next[k] = delta_reg[k + 1];
                    end
                end
                m_next = nsched_reg - 1'b1;
                j_next = CNT_W'(pos_reg);
            end
            CMD_PLACE_STEP:
            begin
                t_next = t_reg - delta_reg[j_idx];
                j_next = j_reg + 1'b1;
            end
            CMD_PLACE_INS:
            begin
                for (int k = 1; k < MAX_PROCS; k++)
                begin
                    if (k > int'(j_reg) && k <= int'(m_reg))
                    begin
                        order_next[k] = order_reg[k - 1];
                        delta_next[k] = delta_reg[k - 1];
                    end
                    // entry that now follows the inserted one loses its share
                    if (k == int'(j_reg) + 1 && j_reg < m_reg)
                        delta_next[k] = delta_reg[k - 1] - t_reg;
                end
                for (int k = 0; k < MAX_PROCS; k++)
                begin
                    if (k == int'(j_reg))
                    begin
                        order_next[k] = pid_reg;
                        delta_next[k] = t_reg;
                    end
                end
            end
            CMD_SEARCH_INIT: j_next = '0;
            CMD_SEARCH_STEP: j_next = j_reg + 1'b1;
            CMD_BAD_ID:      code_next = ST_BAD_ID;
            CMD_PAUSE_MUL:
            begin
                pid_next   = order_reg[j_idx];
                pos_next   = j_idx;
                mul_a_next = factor_reg[order_reg[j_idx]];
                mul_b_next = HALF_W'(ticks_reg);
            end
            CMD_PAUSE_APPLY:
            begin
                if (!p1_in)
                    delta_next[pos_reg] = sat_add(delta_reg[pos_reg], prod_sat);
                else if (!stat.pause_moves)
                begin
                    delta_next[pos_reg] = sat_add(delta_reg[pos_reg], prod_sat);
                    delta_next[p1_idx]  = delta_reg[p1_idx] - prod_sat;
                end
                else
                begin
                    // pushed past its successor: fold its gap in, then re-place
                    delta_next[p1_idx] = sat_add(delta_reg[p1_idx], delta_reg[pos_reg]);
                    t_next             = sat_add(delta_reg[pos_reg], prod_sat);
                end
            end
            CMD_BUD_SAVE:
            begin
                if (div_quot >= BUDGET_MAX)
                    bud_next = BUDGET_SAT;
                else
                    bud_next = div_quot[BUDGET_W-1:0] + 1'b1;
            end
            CMD_OUT_LOAD:
            begin
                head_next   = ID_W'(order_reg[0]);
                alone_next  = int'(nsched_reg) < 2;
                budget_next = (int'(nsched_reg) < 2) ? '0 : bud_reg;
                status_next = code_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_W'(1);
            for (int k = 0; k < NUM_SPEEDS; k++)
                speed_reg[k] <= SPEED_W'(1);
            nsched_reg <= CNT_W'(1);
            for (int k = 0; k < MAX_PROCS; k++)
            begin
                order_reg[k]  <= IDX_W'(k);
                delta_reg[k]  <= '0;
                factor_reg[k] <= '0;
            end
            func_reg <= '0;
            code_reg <= ST_OK;
            ovf_reg  <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            m_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            speed_reg  <= speed_next;
            nsched_reg <= nsched_next;
            order_reg  <= order_next;
            delta_reg  <= delta_next;
            factor_reg <= factor_next;
            func_reg   <= func_next;
            code_reg   <= code_next;
            ovf_reg    <= ovf_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            m_reg      <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        ticks_reg  <= ticks_next;
        l_reg      <= l_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        pos_reg    <= pos_next;
        pid_reg    <= pid_next;
        t_reg      <= t_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        p_lo_reg   <= p_lo_next;
        p_hi_reg   <= p_hi_next;
        bud_reg    <= bud_next;
        head_reg   <= head_next;
        budget_reg <= budget_next;
        alone_reg  <= alone_next;
        status_reg <= status_next;
    end

    assign head_id = head_reg;
    assign budget  = budget_reg;
    assign alone   = alone_reg;
    assign status  = status_reg;

endmodule

// ----- rtl/delta_list_processor_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// delta_list_processor_scheduler_unit
// Delta-list scheduler for emulated processors on one common time base.
// ----------------------------------------------------------------------------
// One item is worked at a time and each item gives exactly one result. Time
// per item is set mostly by the shared iterative divider: with two or more
// processors scheduled, a ran or pause item takes the list search (pause
// only) and walk (one entry a cycle, up to MAX_PROCS), the split multiply
// (low half, then high half) and one budget division; with one processor
// scheduled there is no budget division. A restart item runs Euclid's
// method per processor (one division per remainder step), one division and
// one split multiply for each LCM update, then one division per factor and,
// with two or more scheduled, one for the budget. The result is held in an
// output register, so the block goes back to idle as soon as it is loaded
// and can accept the next item while the previous result waits.
// Configuration writes take effect at once and must only be made while no
// item is in work.
// ----------------------------------------------------------------------------
module delta_list_processor_scheduler_unit #(
    parameter int MAX_PROCS = dlps_pkg::MAX_PROCS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [dlps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlps_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dlps_pkg::FUNC_W-1:0]     func,
    input  logic [dlps_pkg::ID_W-1:0]       proc_id,
    input  logic [dlps_pkg::TICK_W-1:0]     tick_count,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dlps_pkg::ID_W-1:0]       head_id,
    output logic [dlps_pkg::BUDGET_W-1:0]   budget,
    output logic                           alone,
    output logic [dlps_pkg::STATUS_W-1:0]   status
);
    import dlps_pkg::*;

    dp_cmd_t  cmd;    // sequencer -> datapath, one operation per cycle
    dp_stat_t stat;   // datapath flags the sequencer branches on

    // Sequencer: walks restart (LCM, factors), ran (remove, re-place), pause
    // (search, delay, maybe re-place), then budget division for 2+ scheduled.
    dlps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: holds the config, the delta list and factors, the split
    // 32x32 multiplier and the iterative divider, and the result register.
    dlps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .proc_id    (proc_id),
        .tick_count (tick_count),
        .cmd        (cmd),
        .stat       (stat),
        .head_id    (head_id),
        .budget     (budget),
        .alone      (alone),
        .status     (status)
    );

endmodule

// ----- tb/sv/delta_list_processor_scheduler_unit_checker.sv -----
// ----------------------------------------------------------------------------
// delta_list_processor_scheduler_unit_checker
// Watches both channels, keeps a shadow delta list and compares every result.
// ----------------------------------------------------------------------------
module delta_list_processor_scheduler_unit_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dlps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dlps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [dlps_pkg::FUNC_W-1:0]     func,
    input  logic [dlps_pkg::ID_W-1:0]       proc_id,
    input  logic [dlps_pkg::TICK_W-1:0]     tick_count,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [dlps_pkg::ID_W-1:0]       head_id,
    input  logic [dlps_pkg::BUDGET_W-1:0]   budget,
    input  logic                            alone,
    input  logic [dlps_pkg::STATUS_W-1:0]   status,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dlps_pkg::*;

    localparam int NP = MAX_PROCS_DEF;

    typedef struct packed {
        logic [ID_W-1:0]     head;
        logic [BUDGET_W-1:0] bud;
        logic                solo;
        logic [STATUS_W-1:0] st;
    } sched_result_t;

    logic [ACTIVE_W-1:0]  act_reg;
    logic [SPEED_W-1:0]   speed_reg [NUM_SPEEDS];
    logic [ID_W-1:0]      order_q [NP];
    logic [TIME_W-1:0]    delta_q [NP];
    logic [TIME_W-1:0]    factor_q [NP];
    int                   n_sched;
    sched_result_t        expected_results [$];

    assign pending = expected_results.size();

    function automatic logic [TIME_W-1:0] mul_sat(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
        if (b != 0 && a > TIME_MAX / b) return TIME_MAX;
        return a * b;
    endfunction

    function automatic logic [TIME_W-1:0] eff_speed(int i);
        return (speed_reg[i] == 0) ? 64'd1 : {32'd0, speed_reg[i]};
    endfunction

    task automatic drop_entry(int pos, int m);
        for (int k = pos; k + 1 < m && k + 1 < NP; k++)
        begin
            order_q[k] = order_q[k + 1];
            delta_q[k] = delta_q[k + 1];
        end
    endtask

    task automatic insert_entry(int m, int start, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] t);
        int j;
        j = start;
        while (j < m && t > delta_q[j])
        begin
            t -= delta_q[j];
            j++;
        end
        for (int k = m; k > j && k < NP; k--)
        begin
            order_q[k] = order_q[k - 1];
            delta_q[k] = delta_q[k - 1];
        end
        if (j < NP)
        begin
            order_q[j] = id;
            delta_q[j] = t;
            if (j + 1 < m + 1 && j + 1 < NP) delta_q[j + 1] -= t;
        end
    endtask

    task automatic predict_schedule(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                    logic [TICK_W-1:0] ticks);
        sched_result_t r;
        logic [TIME_W-1:0] l, b, m, g, rm, q, c, t, fac;
        logic ovf;
        int p, h;
        r.st = ST_OK;
        if (f == FUNC_RESTART)
        begin
            n_sched = (act_reg == 0) ? 1 : (act_reg > NP ? NP : int'(act_reg));
            l = 1;
            ovf = 0;
            for (int i = 0; i < n_sched && !ovf; i++)
            begin
                b = eff_speed(i);
                m = l; g = b; rm = m % g;
                while (rm != 0)
                begin
                    m = g; g = rm; rm = m % g;
                end
                q = l / g;
                if (q > TIME_MAX / b)
                begin
                    ovf = 1; l = TIME_MAX;
                end
                else l = q * b;
            end
            for (int i = 0; i < NP; i++)
            begin
                order_q[i] = ID_W'(i);
                delta_q[i] = 0;
                factor_q[i] = (i < n_sched) ? l / eff_speed(i) : 0;
            end
            if (ovf) r.st = ST_LCM_OVF;
        end
        else if (f == FUNC_RAN)
        begin
            if (n_sched >= 2)
            begin
                h = order_q[0];
                drop_entry(0, n_sched);
                insert_entry(n_sched - 1, 0, ID_W'(h),
                             mul_sat({44'd0, ticks}, factor_q[h]));
            end
        end
        else if (f == FUNC_PAUSE)
        begin
            for (p = 0; p < n_sched; p++)
                if (order_q[p] == id) break;
            if (p >= n_sched) r.st = ST_BAD_ID;
            else
            begin
                c = mul_sat({44'd0, ticks}, factor_q[id]);
                if (p + 1 >= n_sched) delta_q[p] = sat_add(delta_q[p], c);
                else if (c <= delta_q[p + 1])
                begin
                    delta_q[p] = sat_add(delta_q[p], c);
                    delta_q[p + 1] -= c;
                end
                else
                begin
                    delta_q[p + 1] = sat_add(delta_q[p + 1], delta_q[p]);
                    t = sat_add(delta_q[p], c);
                    drop_entry(p, n_sched);
                    insert_entry(n_sched - 1, p, id, t);
                end
            end
        end
        r.head = order_q[0];
        if (n_sched < 2)
        begin
            r.bud = 0; r.solo = 1;
        end
        else
        begin
            fac = factor_q[order_q[0]];
            q = delta_q[1] / (fac == 0 ? 64'd1 : fac);
            r.bud = (q >= BUDGET_MAX) ? BUDGET_SAT : BUDGET_W'(q + 1);
            r.solo = 0;
        end
        expected_results.push_back(r);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        act_reg = 1;
        n_sched = 1;
        for (int i = 0; i < NP; i++)
        begin
            order_q[i] = ID_W'(i); delta_q[i] = 0; factor_q[i] = 0; speed_reg[i] = 1;
        end
    end

    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACTIVE) act_reg = cfg_data[ACTIVE_W-1:0];
                else if (cfg_index <= NUM_SPEEDS) speed_reg[cfg_index - 1] = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0) report("unexpected result", head_id, 0);
                else
                begin
                    e = expected_results.pop_front();
                    if (head_id !== e.head) report("head_id", head_id, e.head);
                    if (budget !== e.bud) report("budget", budget, e.bud);
                    if (alone !== e.solo) report("alone", alone, e.solo);
                    if (status !== e.st) report("status", status, e.st);
                end
            end
            if (in_valid && in_ready) predict_schedule(func, proc_id, tick_count);
        end
    end
endmodule

// ----- tb/sv/delta_list_processor_scheduler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// delta_list_processor_scheduler_unit_tb
// Drives restart, ran and pause items through several speed settings.
// ----------------------------------------------------------------------------
// Each phase writes the count and speeds while idle, restarts, then runs a
// mix of ran and pause items. The checker predicts every result.
// ----------------------------------------------------------------------------
module delta_list_processor_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dlps_pkg::*;

    logic                  clk, rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid, in_ready;
    logic [FUNC_W-1:0]     func;
    logic [ID_W-1:0]       proc_id;
    logic [TICK_W-1:0]     tick_count;
    logic                  out_valid, out_ready;
    logic [ID_W-1:0]       head_id;
    logic [BUDGET_W-1:0]   budget;
    logic                  alone;
    logic [STATUS_W-1:0]   status;
    int                    fail_count, pending;
    int                    cycle_count;
    bit                    calm;     // no idling at the end

    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;   // unused function

    delta_list_processor_scheduler_unit uut (.*);
    delta_list_processor_scheduler_unit_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: reports a mismatch and stops once cycle_count passes CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("delta_list_processor_scheduler_unit: mismatch");
            $finish;
        end
    end

    // Receiver: random stall bursts, none once calm.
    initial
    begin
        int burst;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_ready <= 0;
                repeat (burst) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Send one item; idle bursts before it unless calm. Called at a falling
    // edge; valid stays high into the next call when no idling follows.
    task automatic send_item(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                             logic [TICK_W-1:0] t);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1; func <= f; proc_id <= id; tick_count <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic set_speeds(logic [2:0] cnt, logic [31:0] s0, logic [31:0] s1,
                              logic [31:0] s2, logic [31:0] s3);
        write_reg(CFG_ACTIVE, CFG_DATA_W'(cnt));
        write_reg(CFG_SPEED0, s0);
        write_reg(CFG_IDX_W'(CFG_SPEED0 + 1), s1);
        write_reg(CFG_IDX_W'(CFG_SPEED0 + 2), s2);
        write_reg(CFG_IDX_W'(CFG_SPEED0 + 3), s3);
    endtask

    function automatic logic [TICK_W-1:0] rand_ticks();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return TICK_W'($urandom_range(0, 15));
            default: return TICK_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return '1;
            2: return $urandom_range(1, 64);
            3: return $urandom_range(1, 12) * 1000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int n_items;
        logic [FUNC_W-1:0] f;
        cycle_count = 0; calm = 0;
        rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; func = '0; proc_id = '0; tick_count = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: items before any restart, then a simple two-speed list.
        send_item(FUNC_RAN, 0, 5);
        send_item(FUNC_PAUSE, 3, 7);
        send_item(FUNC_NONE, 0, 0);
        send_item(FUNC_RESTART, 0, 0);
        wait_drained();
        set_speeds(3'd2, 32'd3, 32'd2, 32'd5, 32'd7);
        send_item(FUNC_RESTART, 0, 0);
        send_item(FUNC_RAN, 0, 1);
        send_item(FUNC_RAN, 0, '1);
        send_item(FUNC_PAUSE, 1, 0);
        send_item(FUNC_PAUSE, 0, '1);
        send_item(FUNC_PAUSE, 2, 3);
        send_item(FUNC_NONE, 3, '1);
        wait_drained();
        // Count above range, zero speed, LCM overflow.
        set_speeds(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'd0);
        send_item(FUNC_RESTART, 0, 0);
        send_item(FUNC_RAN, 0, '1);
        send_item(FUNC_PAUSE, 3, '1);
        send_item(FUNC_PAUSE, 1, 1);
        send_item(FUNC_RAN, 2, 0);
        wait_drained();
        set_speeds(3'd0, 32'd1, 32'd1, 32'd1, 32'd1);
        send_item(FUNC_RESTART, 0, 0);
        send_item(FUNC_RAN, 0, 9);
        send_item(FUNC_PAUSE, 0, 9);
        send_item(FUNC_PAUSE, 1, 9);
        wait_drained();

        // Random phases: mostly ran/pause after a restart, some noise.
        n_items = 0;
        while (n_items < 650)
        begin
            set_speeds(3'($urandom_range(0, 7)), rand_speed(), rand_speed(),
                       rand_speed(), rand_speed());
            if (n_items > 560) calm = 1;
            send_item(FUNC_RESTART, ID_W'($urandom), TICK_W'($urandom));
            n_items++;
            repeat ($urandom_range(10, 30))
            begin
                case ($urandom_range(0, 19))
                    0: f = FUNC_NONE;
                    1: f = FUNC_RESTART;
                    2, 3, 4, 5, 6, 7, 8: f = FUNC_PAUSE;
                    default: f = FUNC_RAN;
                endcase
                send_item(f, ID_W'($urandom), rand_ticks());
                n_items++;
            end
            wait_drained();
        end

        wait_drained();
        if (fail_count == 0)
            $display("delta_list_processor_scheduler_unit: match");
        else
            $display("delta_list_processor_scheduler_unit: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/dlps_pkg.sv
rtl/dlps_div.sv
rtl/dlps_ctrl.sv
rtl/dlps_dp.sv
rtl/delta_list_processor_scheduler_unit.sv
tb/sv/delta_list_processor_scheduler_unit_checker.sv
tb/sv/delta_list_processor_scheduler_unit_tb.sv
